// ===== rtl/psm_pkg.sv =====
// Package for the prime sieve marker unit: field widths, reset values,
// queue item and status types, and the back-end state encoding.
// Depends on nothing; every other file of the block imports it, but for psm_ram and psm_checker.
`timescale 1ns / 1ps

package psm_pkg;

   localparam int unsigned CW            = 13;           // number field width
   localparam int unsigned MW            = CW + 1;       // multiple accumulator
   localparam int unsigned MAX_N_DEFAULT = 4096;
   localparam logic [CW-1:0] LIMIT_RESET = 13'd4096;
   localparam int unsigned QUEUE_DEPTH   = 2;

   typedef enum logic [1:0] {
      CLS_LOOKUP,   // in range and at least two: read the map
      CLS_SMALL,    // zero or one: never prime
      CLS_OOR       // above the effective limit
   } cls_type;

   typedef struct packed {
      logic [CW-1:0] candidate;
      logic          start_new;
      logic [CW-1:0] eff_limit;
      cls_type       cls;
   } q_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_flags_type;

   typedef struct packed {
      logic init_busy;   // power-on clearing pass in progress
   } back_status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_DECIDE,
      BK_MARK
   } back_state_type;

endpackage

// ===== rtl/psm_chan_if.sv =====
// Channel interfaces of the prime sieve marker unit: candidate requests
// and sieve responses, each with valid/ready. Depends on psm_pkg.
`timescale 1ns / 1ps

interface psm_req_if;
   import psm_pkg::*;

   logic          valid;
   logic          ready;
   logic [CW-1:0] candidate;
   logic          start_new;

   modport source (output valid, candidate, start_new, input ready);
   modport sink   (input valid, candidate, start_new, output ready);
endinterface

interface psm_rsp_if;
   import psm_pkg::*;

   logic          valid;
   logic          ready;
   logic [CW-1:0] number;
   logic          prime;
   logic          out_of_range;

   modport source (output valid, number, prime, out_of_range, input ready);
   modport sink   (input valid, number, prime, out_of_range, output ready);
endinterface

// ===== rtl/prime_sieve_marker_unit.sv =====
// Top level of the prime sieve marker unit: front end, item queue and
// sieve back end. Depends on psm_pkg, psm_chan_if and the psm_* modules.
//
//   channel   direction  handshake       payload
//   req_chan  in         valid / ready   candidate[12:0], start_new
//   rsp_chan  out        valid / ready   number[12:0], prime, out_of_range
//   csr_*     in         csr_wr_en       csr_wr_data[12:0] (limit)
//
// Back end: a candidate that is not prime, or is out of range, passes
// through BK_DECIDE (after BK_READ for a lookup); a prime p then marks its
// multiples up to L in BK_MARK, one store write per marked multiple (L = effective limit).
// A start_new transaction adds a store clearing sweep over all MAX_N + 1 entries.
// Reset: synchronous; a clearing pass over the store follows, and
// req_chan.ready stays low until it ends.
// Stalls: responses sit in an output register; the queue keeps accepting
// while a response waits, until the queue is full.
`timescale 1ns / 1ps

module prime_sieve_marker_unit #(
   parameter int unsigned MAX_N = psm_pkg::MAX_N_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   psm_req_if.sink                req_chan,
   psm_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [psm_pkg::CW-1:0] csr_wr_data
);
   import psm_pkg::*;

   // hand-over between the front and back ends
   logic            push, pop;
   q_item_type      push_item, pop_item;
   q_flags_type     q_flags;
   back_status_type back_status;

   // Classify each transaction against the clamped limit and queue it.
   psm_front #(
      .MAX_N (MAX_N)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_flags     (q_flags),
      .back_status (back_status),
      .push        (push),
      .push_item   (push_item)
   );

   // Decouple acceptance from the long marking runs.
   psm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_flags   (q_flags)
   );

   // Clear, look up, respond, then mark multiples one write per cycle.
   psm_back #(
      .MAX_N (MAX_N)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_item    (pop_item),
      .q_flags     (q_flags),
      .pop         (pop),
      .back_status (back_status),
      .rsp_chan    (rsp_chan)
   );

endmodule

// ===== rtl/psm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module psm_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 4097
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/psm_front.sv =====
// Front end: holds the limit register, accepts candidate transactions and
// classifies them into queue items. Depends on psm_pkg and psm_chan_if.
`timescale 1ns / 1ps

module psm_front #(
   parameter int unsigned MAX_N = psm_pkg::MAX_N_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   psm_req_if.sink                 req_chan,
   input  logic                    csr_wr_en,
   input  logic [psm_pkg::CW-1:0]  csr_wr_data,
   input  psm_pkg::q_flags_type    q_flags,
   input  psm_pkg::back_status_type back_status,
   output logic                    push,
   output psm_pkg::q_item_type     push_item
);
   import psm_pkg::*;

   localparam int unsigned AW = $clog2(MAX_N + 1);
   localparam int unsigned EW = (AW > CW) ? AW : CW;

   logic [CW-1:0] limit_ff, limit_in;
   logic [EW-1:0] limit_w, eff_w;
   logic [CW-1:0] eff_limit;

   always_comb begin
      limit_in = csr_wr_en ? csr_wr_data : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   // Clamp the limit to the store; the result never exceeds the limit.
   always_comb begin
      limit_w   = EW'(limit_ff);
      eff_w     = (limit_w < EW'(MAX_N)) ? limit_w : EW'(MAX_N);
      eff_limit = CW'(eff_w);
   end

   assign req_chan.ready = !q_flags.full && !back_status.init_busy;
   assign push           = req_chan.valid && req_chan.ready;

   always_comb begin
      push_item.candidate = req_chan.candidate;
      push_item.start_new = req_chan.start_new;
      push_item.eff_limit = eff_limit;
      if (req_chan.candidate > eff_limit) begin
         push_item.cls = CLS_OOR;
      end else if (req_chan.candidate < CW'(2)) begin
         push_item.cls = CLS_SMALL;
      end else begin
         push_item.cls = CLS_LOOKUP;
      end
   end

endmodule

// ===== rtl/psm_queue.sv =====
// Short FIFO of classified items between front and back end.
// Depends on psm_pkg.
`timescale 1ns / 1ps

module psm_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  psm_pkg::q_item_type  push_item,
   input  logic                 pop,
   output psm_pkg::q_item_type  pop_item,
   output psm_pkg::q_flags_type q_flags
);
   import psm_pkg::*;

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

   q_item_type    entries_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign q_flags.full  = (count_ff == NW'(QUEUE_DEPTH));
   assign q_flags.empty = (count_ff == '0);
   assign do_push       = push && !q_flags.full;
   assign do_pop        = pop && !q_flags.empty;
   assign pop_item      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/psm_back.sv =====
// Back end: sieve sequencer over the composite bit store. Clears the store,
// looks up candidates, posts responses and marks multiples.
// Depends on psm_pkg, psm_chan_if and psm_ram.
`timescale 1ns / 1ps

module psm_back #(
   parameter int unsigned MAX_N = psm_pkg::MAX_N_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  psm_pkg::q_item_type      pop_item,
   input  psm_pkg::q_flags_type     q_flags,
   output logic                     pop,
   output psm_pkg::back_status_type back_status,
   psm_rsp_if.source                rsp_chan
);
   import psm_pkg::*;

   localparam int unsigned DEPTH = MAX_N + 1;
   localparam int unsigned AW    = $clog2(DEPTH);

   back_state_type state_ff, state_in;
   q_item_type     item_ff, item_in;
   logic           pending_ff, pending_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [MW-1:0]  mult_ff, mult_in;
   logic [MW-1:0]  dbl;
   logic [MW-1:0]  mult_next;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]  rsp_number_ff;
   logic           rsp_prime_ff, rsp_oor_ff;
   logic           load_rsp, slot_free, prime_hit;

   logic           wr_en, wr_data, rd_en, rd_data;
   logic [AW-1:0]  wr_addr, rd_addr;

   psm_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign dbl       = {item_ff.candidate, 1'b0};
   assign mult_next = mult_ff + MW'(item_ff.candidate);
   assign prime_hit = (item_ff.cls == CLS_LOOKUP) && !rd_data;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      pending_in   = pending_ff;
      clr_in       = clr_ff;
      mult_in      = mult_ff;
      pop          = 1'b0;
      load_rsp     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = AW'(item_ff.candidate);

      unique case (state_ff)
         BK_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_N)) begin
               clr_in     = '0;
               pending_in = 1'b0;
               if (!pending_ff) begin
                  state_in = BK_IDLE;
               end else if (item_ff.cls == CLS_LOOKUP) begin
                  state_in = BK_READ;
               end else begin
                  state_in = BK_DECIDE;
               end
            end
         end
         BK_IDLE: begin
            if (!q_flags.empty) begin
               pop     = 1'b1;
               item_in = pop_item;
               if (pop_item.start_new) begin
                  pending_in = 1'b1;
                  state_in   = BK_CLEAR;
               end else if (pop_item.cls == CLS_LOOKUP) begin
                  state_in = BK_READ;
               end else begin
                  state_in = BK_DECIDE;
               end
            end
         end
         BK_READ: begin
            rd_en    = 1'b1;
            state_in = BK_DECIDE;
         end
         BK_DECIDE: begin
            // read data holds until the next lookup, so wait for the slot here
            if (slot_free) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               if (prime_hit && (dbl <= MW'(item_ff.eff_limit))) begin
                  mult_in  = dbl;
                  state_in = BK_MARK;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_MARK: begin
            wr_en   = 1'b1;
            wr_addr = AW'(mult_ff);
            wr_data = 1'b1;
            mult_in = mult_next;
            if (mult_next > MW'(item_ff.eff_limit)) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         pending_ff   <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      mult_ff <= mult_in;
      if (load_rsp) begin
         rsp_number_ff <= item_ff.candidate;
         rsp_prime_ff  <= prime_hit;
         rsp_oor_ff    <= (item_ff.cls == CLS_OOR);
      end
   end

   assign back_status.init_busy = (state_ff == BK_CLEAR) && !pending_ff;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.number       = rsp_number_ff;
   assign rsp_chan.prime        = rsp_prime_ff;
   assign rsp_chan.out_of_range = rsp_oor_ff;

endmodule

// ===== rtl/psm_checker.sv =====
// Port-level checker for the prime sieve marker unit, bound to the top
// level. Depends on nothing beyond the top level's ports.
`timescale 1ns / 1ps

module psm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_number_lsb,
   input logic rsp_prime,
   input logic rsp_out_of_range
);

   logic [3:0] outstanding_ff, outstanding_in;

   always_comb begin
      outstanding_in = outstanding_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         outstanding_in = outstanding_ff + 4'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         outstanding_in = outstanding_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   // check that requests are held off straight after reset, as the store sweep begins
   a_init_not_ready: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during power-on clearing");

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_number_lsb)
         && $stable(rsp_prime) && $stable(rsp_out_of_range))
      else $error("stalled response changed");

   // every response answers an earlier accepted transaction
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 4'd0)
      else $error("response without outstanding transaction");

endmodule

bind prime_sieve_marker_unit psm_checker u_psm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_number_lsb   (rsp_chan.number[0]),
   .rsp_prime        (rsp_chan.prime),
   .rsp_out_of_range (rsp_chan.out_of_range)
);
